// ===== rtl/wftc_pkg.sv =====
// Shared types and codes for the window frequency threshold counter.
// No dependencies; used by the top module of the block.
package wftc_pkg;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_SPARE  = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_ADD_FULL = 2'd2,
        ST_UNUSED   = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [9:0]  item_value;
        logic [10:0] threshold;
    } t_in_beat;

    typedef struct packed {
        logic [10:0] values_at_threshold;
        logic [1:0]  status;
    } t_out_beat;

endpackage

// ===== rtl/wftc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds both tables of the counter.
module wftc_ram #(
    parameter int W = 8,
    parameter int D = 64,
    localparam int AW = (D > 1) ? $clog2(D) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/wftc_alu.sv =====
// Shared increment/decrement unit, used for the count and the level updates.
// No dependencies.
module wftc_alu #(
    parameter int W = 11
) (
    input  logic [W-1:0] i_a,
    input  logic         i_dec,
    output logic [W-1:0] o_y
);

    always_comb begin
        if (i_dec) begin
            o_y = i_a - W'(1);
        end else begin
            o_y = i_a + W'(1);
        end
    end

endmodule

// ===== rtl/window_frequency_threshold_counter.sv =====
// Count-of-counts tracker: occurrence count per value plus a level table.
// One item is handled at a time; no new beat is taken until the result is
// emitted. One shared +/-1 unit and one read port per table set the
// sequence (read count, update count, update level, read threshold, emit).
// After reset a clearing pass zeroes both tables; no input is taken.
module window_frequency_threshold_counter #(
    parameter int NUM_VALUES = 1024,
    parameter int MAX_COUNT  = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  wftc_pkg::t_in_beat    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output wftc_pkg::t_out_beat   o_out_data
);

    localparam int AWC  = (NUM_VALUES > 1) ? $clog2(NUM_VALUES) : 1;
    localparam int AWL  = $clog2(MAX_COUNT + 1);
    localparam int CW   = $clog2(MAX_COUNT + 1);
    localparam int LW   = $clog2(NUM_VALUES + 1);
    localparam int DW   = (CW > LW) ? CW : LW;
    localparam int CLRN = (NUM_VALUES > MAX_COUNT + 1) ? NUM_VALUES : MAX_COUNT + 1;
    localparam int CLW  = $clog2(CLRN);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RDCNT = 7'b0000100,
        S_CNT   = 7'b0001000,
        S_LVL   = 7'b0010000,
        S_RDK   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    wftc_pkg::t_in_beat  r_item, n_item;
    logic [AWL-1:0]      r_lvl_idx, n_lvl_idx;
    logic                r_mut, n_mut;
    wftc_pkg::t_status   r_status, n_status;
    logic [CLW-1:0]      r_clr, n_clr;
    wftc_pkg::t_out_beat r_out, n_out;
    logic                r_ovalid, n_ovalid;

    logic           cnt_we, lvl_we;
    logic [AWC-1:0] cnt_waddr, cnt_raddr;
    logic [CW-1:0]  cnt_wdata, cnt_rdata;
    logic [AWL-1:0] lvl_waddr, lvl_raddr;
    logic [LW-1:0]  lvl_wdata, lvl_rdata;
    logic [DW-1:0]  alu_a, alu_y;
    logic           alu_dec;

    logic           in_range, k_ok, is_add, is_rem, load_ok;
    logic [AWC-1:0] v_idx;
    logic [AWL-1:0] k_idx;

    wftc_ram #(.W(CW), .D(NUM_VALUES)) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (cnt_we),
        .i_waddr(cnt_waddr),
        .i_wdata(cnt_wdata),
        .i_raddr(cnt_raddr),
        .o_rdata(cnt_rdata)
    );

    wftc_ram #(.W(LW), .D(MAX_COUNT + 1)) u_lvl_ram (
        .i_clk  (i_clk),
        .i_we   (lvl_we),
        .i_waddr(lvl_waddr),
        .i_wdata(lvl_wdata),
        .i_raddr(lvl_raddr),
        .o_rdata(lvl_rdata)
    );

    wftc_alu #(.W(DW)) u_alu (
        .i_a  (alu_a),
        .i_dec(alu_dec),
        .o_y  (alu_y)
    );

    assign is_add   = (r_item.opcode == wftc_pkg::OP_ADD);
    assign is_rem   = (r_item.opcode == wftc_pkg::OP_REMOVE);
    assign in_range = (32'(r_item.item_value) < NUM_VALUES);
    assign k_ok     = (r_item.threshold != 11'd0) && (32'(r_item.threshold) <= MAX_COUNT);
    assign v_idx    = AWC'(r_item.item_value);
    assign k_idx    = AWL'(r_item.threshold);
    assign load_ok  = !r_ovalid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        n_item    = r_item;
        n_lvl_idx = r_lvl_idx;
        n_mut     = r_mut;
        n_status  = r_status;
        n_clr     = r_clr;
        n_out     = r_out;
        n_ovalid  = r_ovalid && i_out_stall;

        cnt_we    = 1'b0;
        cnt_waddr = v_idx;
        cnt_wdata = alu_y[CW-1:0];
        cnt_raddr = v_idx;
        lvl_we    = 1'b0;
        lvl_waddr = r_lvl_idx;
        lvl_wdata = alu_y[LW-1:0];
        lvl_raddr = k_idx;
        alu_a     = DW'(lvl_rdata);
        alu_dec   = is_rem;

        unique case (r_state)
            S_CLEAR: begin
                // sweep both tables to zero
                cnt_waddr = AWC'(r_clr);
                cnt_wdata = '0;
                cnt_we    = (32'(r_clr) < NUM_VALUES);
                lvl_waddr = AWL'(r_clr);
                lvl_wdata = '0;
                lvl_we    = (32'(r_clr) < MAX_COUNT + 1);
                n_clr     = r_clr + CLW'(1);
                if (32'(r_clr) == CLRN - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_RDCNT;
                end
            end
            S_RDCNT: begin
                n_state = S_CNT;
            end
            S_CNT: begin
                alu_a    = DW'(cnt_rdata);
                n_status = wftc_pkg::ST_OK;
                n_mut    = 1'b0;
                if (in_range && is_add) begin
                    if (32'(cnt_rdata) >= MAX_COUNT) begin
                        n_status = wftc_pkg::ST_ADD_FULL;
                    end else begin
                        n_mut = 1'b1;
                    end
                end else if (in_range && is_rem) begin
                    if (cnt_rdata == '0) begin
                        n_status = wftc_pkg::ST_ABSENT;
                    end else begin
                        n_mut = 1'b1;
                    end
                end
                cnt_we = n_mut;
                // add bumps the level at the new count, remove at the old one
                n_lvl_idx = is_add ? AWL'(alu_y[CW-1:0]) : AWL'(cnt_rdata);
                lvl_raddr = n_lvl_idx;
                n_state   = S_LVL;
            end
            S_LVL: begin
                lvl_we  = r_mut;
                n_state = S_RDK;
            end
            S_RDK: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (load_ok) begin
                    n_out.values_at_threshold = k_ok ? 11'(32'(lvl_rdata)) : 11'd0;
                    n_out.status              = r_status;
                    n_ovalid                  = 1'b1;
                    n_state                   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ovalid <= 1'b0;
            r_mut    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ovalid <= n_ovalid;
            r_mut    <= n_mut;
        end
        r_item    <= n_item;
        r_lvl_idx <= n_lvl_idx;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_out_valid)
        else $error("result beat during clearing pass");

    a_rose_from_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result beat without completed item");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cnt_we |-> (32'(cnt_wdata) <= MAX_COUNT))
        else $error("occurrence count above maximum");

    a_reject_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LVL && r_status != wftc_pkg::ST_OK) |-> !lvl_we)
        else $error("rejected item changed the level table");

endmodule
